// ----- rtl/gda_pkg.sv -----
// Shared types, codes and calendar tables for the Gregorian date block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package gda_pkg;

	localparam int unsigned MAX_YEAR_DEF = 9999;

	// Operation codes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_DIFF = 2'd2;
	localparam logic [1:0] OP_CMP  = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_DATE = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;

	// Datapath commands
	typedef logic [3:0] cmd_t;
	localparam cmd_t C_NONE  = 4'd0;
	localparam cmd_t C_LATCH = 4'd1;
	localparam cmd_t C_YB1   = 4'd2;
	localparam cmd_t C_YB2   = 4'd3;
	localparam cmd_t C_CHKG  = 4'd4;
	localparam cmd_t C_DNS   = 4'd5;
	localparam cmd_t C_ADD   = 4'd6;
	localparam cmd_t C_GUESS = 4'd7;
	localparam cmd_t C_SEED  = 4'd8;
	localparam cmd_t C_STEP  = 4'd9;
	localparam cmd_t C_BACK  = 4'd10;
	localparam cmd_t C_REM   = 4'd11;
	localparam cmd_t C_MON   = 4'd12;
	localparam cmd_t C_FIN   = 4'd13;

	typedef struct packed {
		logic [1:0] op;
		logic       range_bad;
		logic       base_le;
		logic       mon_done;
	} dp_stat_t;

	// x / 100 == (x * 5243) >> 19 for x below 43699
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int unsigned DIV100_SH  = 19;
	// floor(2^32 / 365.2425), rounded down so the year estimate never overshoots
	localparam logic [23:0] INV_YEAR_MUL = 24'd11759221;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = lp ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// Days before the first of month m in a common year
	function automatic logic [8:0] cum_days(input logic [3:0] m);
		logic [8:0] c;
		case (m)
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			default: c = 9'd0;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/gda_in_if.sv -----
// Request channel interface: valid/ready plus the request item fields.
// No dependencies.
`timescale 1ns / 1ps

interface gda_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [13:0]        in_year;
	logic [3:0]         in_month;
	logic [4:0]         in_day;
	logic signed [22:0] day_count;

	modport source (output valid, op, in_year, in_month, in_day, day_count, input ready);
	modport sink (input valid, op, in_year, in_month, in_day, day_count, output ready);
endinterface

// ----- rtl/gda_out_if.sv -----
// Response channel interface: valid/ready plus the result item fields.
// No dependencies.
`timescale 1ns / 1ps

interface gda_out_if;
	logic               valid;
	logic               ready;
	logic [13:0]        cur_year;
	logic [3:0]         cur_month;
	logic [4:0]         cur_day;
	logic signed [22:0] day_difference;
	logic               is_less;
	logic               is_equal;
	logic [1:0]         status;

	modport source (output valid, cur_year, cur_month, cur_day, day_difference,
		is_less, is_equal, status, input ready);
	modport sink (input valid, cur_year, cur_month, cur_day, day_difference,
		is_less, is_equal, status, output ready);
endinterface

// ----- rtl/gda_datapath.sv -----
// Datapath: stored date, day-number unit, year search and month walk, result register.
// Depends on gda_pkg; driven by gda_ctrl commands.
`timescale 1ns / 1ps

module gda_datapath #(
	parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gda_pkg::cmd_t      cmd,
	output gda_pkg::dp_stat_t  stat,
	input  logic [1:0]         op,
	input  logic [13:0]        in_year,
	input  logic [3:0]         in_month,
	input  logic [4:0]         in_day,
	input  logic signed [22:0] day_count,
	output logic [13:0]        cur_year,
	output logic [3:0]         cur_month,
	output logic [4:0]         cur_day,
	output logic signed [22:0] day_difference,
	output logic               is_less,
	output logic               is_equal,
	output logic [1:0]         status
);

	localparam int unsigned LP = MAX_YEAR - 1;
	localparam int unsigned LEAP_TOP =
		(((MAX_YEAR % 4) == 0) && ((MAX_YEAR % 100) != 0)) || ((MAX_YEAR % 400) == 0) ? 1 : 0;
	localparam int unsigned TOP = 365 * LP + LP / 4 - LP / 100 + LP / 400 + 364 + LEAP_TOP;
	localparam logic [13:0]        MAX_Y    = 14'(MAX_YEAR);
	localparam logic signed [24:0] TOP_N    = 25'(TOP);
	localparam logic signed [23:0] DIFF_MAX = 24'sd4194303;
	localparam logic signed [23:0] DIFF_MIN = -24'sd4194304;

	// Stored date
	logic [13:0] sy_q;
	logic [3:0]  sm_q;
	logic [4:0]  sd_q;

	// Latched request
	logic [1:0]         op_q;
	logic [13:0]        gy_q;
	logic [3:0]         gm_q;
	logic [4:0]         gd_q;
	logic signed [22:0] cnt_q;

	// Working registers
	logic [14:0]        yb_q;
	logic [14:0]        yr_q;
	logic [22:0]        m365_q;
	logic [7:0]         pq_q;
	logic [8:0]         yq_q;
	logic [22:0]        base_q;
	logic               leap_q;
	logic               val_q;
	logic [22:0]        gn_q;
	logic [22:0]        sn_q;
	logic signed [24:0] n_q;
	logic [46:0]        mul_q;
	logic [8:0]         r_q;
	logic [3:0]         m_q;

	logic [13:0] p;
	logic [26:0] p_prod;
	logic [27:0] y_prod;
	logic [14:0] r100;
	logic        lp;
	logic [22:0] base_n;
	logic [22:0] dn_g;
	logic [22:0] dn_s;
	logic        valid_g;
	logic        range_bad;
	logic        base_le;
	logic [4:0]  cur_len;
	logic        mon_done;
	logic [14:0] g0;
	logic [14:0] cand;
	logic signed [23:0] diff_w;

	logic [13:0]        ny;
	logic [3:0]         nm;
	logic [4:0]         nd;
	logic signed [22:0] ndiff;
	logic               nless;
	logic               neq;
	logic [1:0]         nst;

	// Year base: day number of Jan 1 of yb_q, and its leap flag
	assign p      = yb_q[13:0] - 14'd1;
	assign p_prod = 27'(p) * 27'(gda_pkg::DIV100_MUL);
	assign y_prod = 28'(yb_q) * 28'(gda_pkg::DIV100_MUL);
	assign r100   = yb_q - 15'(yq_q) * 15'd100;
	assign lp     = ((yb_q[1:0] == 2'd0) && (r100 != 15'd0)) ||
	                ((r100 == 15'd0) && (yq_q[1:0] == 2'd0));
	assign base_n = m365_q + 23'(p >> 2) - 23'(pq_q) + 23'(pq_q >> 2);

	assign dn_g = base_q + 23'(gda_pkg::cum_days(gm_q)) + 23'(leap_q && (gm_q > 4'd2)) +
	              23'(gd_q) - 23'd1;
	assign dn_s = base_q + 23'(gda_pkg::cum_days(sm_q)) + 23'(leap_q && (sm_q > 4'd2)) +
	              23'(sd_q) - 23'd1;

	assign valid_g = (gy_q != 14'd0) && (gy_q <= MAX_Y) && (gm_q >= 4'd1) &&
	                 (gm_q <= 4'd12) && (gd_q != 5'd0) &&
	                 (gd_q <= gda_pkg::month_len(gm_q, leap_q));

	assign range_bad = (n_q < 25'sd0) || (n_q > TOP_N);
	assign base_le   = $signed({2'b00, base_q}) <= n_q;
	assign cur_len   = gda_pkg::month_len(m_q, leap_q);
	assign mon_done  = !((m_q < 4'd12) && (r_q >= 9'(cur_len)));
	assign g0        = mul_q[46:32];
	assign cand      = (g0 == 15'd0) ? 15'd1 : g0;
	assign diff_w    = $signed({1'b0, sn_q}) - $signed({1'b0, gn_q});

	assign stat = '{op: op_q, range_bad: range_bad, base_le: base_le, mon_done: mon_done};

	// Result and next stored date
	always_comb begin
		ny    = sy_q;
		nm    = sm_q;
		nd    = sd_q;
		ndiff = 23'sd0;
		nless = 1'b0;
		neq   = 1'b0;
		nst   = gda_pkg::ST_OK;
		case (op_q)
			gda_pkg::OP_LOAD: begin
				if (val_q) begin
					ny = gy_q;
					nm = gm_q;
					nd = gd_q;
				end else begin
					nst = gda_pkg::ST_BAD_DATE;
				end
			end
			gda_pkg::OP_ADD: begin
				if (range_bad) begin
					nst = gda_pkg::ST_RANGE;
				end else begin
					ny = yr_q[13:0];
					nm = m_q;
					nd = r_q[4:0] + 5'd1;
				end
			end
			gda_pkg::OP_DIFF: begin
				if (!val_q) begin
					nst = gda_pkg::ST_BAD_DATE;
				end else if (diff_w > DIFF_MAX) begin
					ndiff = DIFF_MAX[22:0];
					nst   = gda_pkg::ST_RANGE;
				end else if (diff_w < DIFF_MIN) begin
					ndiff = DIFF_MIN[22:0];
					nst   = gda_pkg::ST_RANGE;
				end else begin
					ndiff = diff_w[22:0];
				end
			end
			default: begin
				nless = (sy_q < gy_q) || ((sy_q == gy_q) && (sm_q < gm_q)) ||
				        ((sy_q == gy_q) && (sm_q == gm_q) && (sd_q < gd_q));
				neq   = (sy_q == gy_q) && (sm_q == gm_q) && (sd_q == gd_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sy_q <= 14'd1;
			sm_q <= 4'd1;
			sd_q <= 5'd1;
		end else if (cmd == gda_pkg::C_FIN) begin
			sy_q <= ny;
			sm_q <= nm;
			sd_q <= nd;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			gda_pkg::C_LATCH: begin
				op_q  <= op;
				gy_q  <= in_year;
				gm_q  <= in_month;
				gd_q  <= in_day;
				cnt_q <= day_count;
				yb_q  <= (op == gda_pkg::OP_ADD) ? {1'b0, sy_q} : {1'b0, in_year};
			end
			gda_pkg::C_YB1: begin
				m365_q <= 23'(p) * 23'd365;
				pq_q   <= p_prod[gda_pkg::DIV100_SH +: 8];
				yq_q   <= y_prod[gda_pkg::DIV100_SH +: 9];
			end
			gda_pkg::C_YB2: begin
				base_q <= base_n;
				leap_q <= lp;
			end
			gda_pkg::C_CHKG: begin
				val_q <= valid_g;
				gn_q  <= dn_g;
				yb_q  <= {1'b0, sy_q};
			end
			gda_pkg::C_DNS:   sn_q  <= dn_s;
			gda_pkg::C_ADD:   n_q   <= $signed({2'b00, sn_q}) + 25'(cnt_q);
			gda_pkg::C_GUESS: mul_q <= 47'(n_q[22:0]) * 47'(gda_pkg::INV_YEAR_MUL);
			gda_pkg::C_SEED: begin
				yr_q <= cand;
				yb_q <= cand + 15'd1;
			end
			gda_pkg::C_STEP: begin
				yr_q <= yb_q;
				yb_q <= yb_q + 15'd1;
			end
			gda_pkg::C_BACK: yb_q <= yr_q;
			gda_pkg::C_REM: begin
				r_q <= n_q[8:0] - base_q[8:0];
				m_q <= 4'd1;
			end
			gda_pkg::C_MON: begin
				if (!mon_done) begin
					r_q <= r_q - 9'(cur_len);
					m_q <= m_q + 4'd1;
				end
			end
			gda_pkg::C_FIN: begin
				cur_year       <= ny;
				cur_month      <= nm;
				cur_day        <= nd;
				day_difference <= ndiff;
				is_less        <= nless;
				is_equal       <= neq;
				status         <= nst;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/gda_ctrl.sv -----
// Controller: sequences the datapath per operation and runs both handshakes.
// Depends on gda_pkg.
`timescale 1ns / 1ps

module gda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output gda_pkg::cmd_t     cmd,
	input  gda_pkg::dp_stat_t stat
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_GY1   = 5'd2;
	localparam logic [4:0] S_GY2   = 5'd3;
	localparam logic [4:0] S_GCHK  = 5'd4;
	localparam logic [4:0] S_SY1   = 5'd5;
	localparam logic [4:0] S_SY2   = 5'd6;
	localparam logic [4:0] S_SDN   = 5'd7;
	localparam logic [4:0] S_ADD   = 5'd8;
	localparam logic [4:0] S_RCHK  = 5'd9;
	localparam logic [4:0] S_GUESS = 5'd10;
	localparam logic [4:0] S_SEED  = 5'd11;
	localparam logic [4:0] S_TY1   = 5'd12;
	localparam logic [4:0] S_TY2   = 5'd13;
	localparam logic [4:0] S_TCHK  = 5'd14;
	localparam logic [4:0] S_BY1   = 5'd15;
	localparam logic [4:0] S_BY2   = 5'd16;
	localparam logic [4:0] S_REM   = 5'd17;
	localparam logic [4:0] S_MON   = 5'd18;
	localparam logic [4:0] S_FIN   = 5'd19;

	logic [4:0] state_q;
	logic [4:0] state_n;
	logic       ov_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		state_n = state_q;
		cmd     = gda_pkg::C_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = gda_pkg::C_LATCH;
					state_n = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.op)
					gda_pkg::OP_ADD: state_n = S_SY1;
					gda_pkg::OP_CMP: state_n = S_FIN;
					default:         state_n = S_GY1;
				endcase
			end
			S_GY1: begin
				cmd     = gda_pkg::C_YB1;
				state_n = S_GY2;
			end
			S_GY2: begin
				cmd     = gda_pkg::C_YB2;
				state_n = S_GCHK;
			end
			S_GCHK: begin
				cmd     = gda_pkg::C_CHKG;
				state_n = (stat.op == gda_pkg::OP_DIFF) ? S_SY1 : S_FIN;
			end
			S_SY1: begin
				cmd     = gda_pkg::C_YB1;
				state_n = S_SY2;
			end
			S_SY2: begin
				cmd     = gda_pkg::C_YB2;
				state_n = S_SDN;
			end
			S_SDN: begin
				cmd     = gda_pkg::C_DNS;
				state_n = (stat.op == gda_pkg::OP_ADD) ? S_ADD : S_FIN;
			end
			S_ADD: begin
				cmd     = gda_pkg::C_ADD;
				state_n = S_RCHK;
			end
			S_RCHK:  state_n = stat.range_bad ? S_FIN : S_GUESS;
			S_GUESS: begin
				cmd     = gda_pkg::C_GUESS;
				state_n = S_SEED;
			end
			S_SEED: begin
				cmd     = gda_pkg::C_SEED;
				state_n = S_TY1;
			end
			S_TY1: begin
				cmd     = gda_pkg::C_YB1;
				state_n = S_TY2;
			end
			S_TY2: begin
				cmd     = gda_pkg::C_YB2;
				state_n = S_TCHK;
			end
			S_TCHK: begin
				if (stat.base_le) begin
					cmd     = gda_pkg::C_STEP;
					state_n = S_TY1;
				end else begin
					cmd     = gda_pkg::C_BACK;
					state_n = S_BY1;
				end
			end
			S_BY1: begin
				cmd     = gda_pkg::C_YB1;
				state_n = S_BY2;
			end
			S_BY2: begin
				cmd     = gda_pkg::C_YB2;
				state_n = S_REM;
			end
			S_REM: begin
				cmd     = gda_pkg::C_REM;
				state_n = S_MON;
			end
			S_MON: begin
				cmd = gda_pkg::C_MON;
				if (stat.mon_done) begin
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				if (!ov_q || out_ready) begin
					cmd     = gda_pkg::C_FIN;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd == gda_pkg::C_FIN) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/gregorian_date_arithmetic.sv -----
// Top level of the Gregorian date block: controller, datapath and checks.
// Depends on gda_pkg, gda_in_if, gda_out_if, gda_ctrl and gda_datapath.
//
// Usage: request items arrive on req (valid/ready), one result item per request
// leaves on rsp (valid/ready). The block holds one date, 0001-01-01 after reset.
// Op load checks and stores a date, op add moves the stored date by a signed day
// count, op difference returns stored minus given date in days, op compare
// reports less/equal against the raw given fields.
// An add whose sum is out of range ends before the year search; otherwise its
// time is set by the year search (one pass of the shared year-base unit per
// candidate year) and by the month walk over the months of the found year.
// One item is in work at a time; req.ready is high only while the sequencer is idle.
// Results sit in an output register, so a new request is taken while the last
// result waits; if rsp stalls, the next result holds in its final step until
// the register frees. Reset is asynchronous and clears the stored date to
// 0001-01-01 and drops any pending result.
`timescale 1ns / 1ps

module gregorian_date_arithmetic #(
	parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
	input logic       clk,
	input logic       arst_n,
	gda_in_if.sink    req,
	gda_out_if.source rsp
);

	gda_pkg::cmd_t     cmd;
	gda_pkg::dp_stat_t stat;

	// Sequencer and handshakes
	gda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Stored date, arithmetic and the result register
	gda_datapath #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.op             (req.op),
		.in_year        (req.in_year),
		.in_month       (req.in_month),
		.in_day         (req.in_day),
		.day_count      (req.day_count),
		.cur_year       (rsp.cur_year),
		.cur_month      (rsp.cur_month),
		.cur_day        (rsp.cur_day),
		.day_difference (rsp.day_difference),
		.is_less        (rsp.is_less),
		.is_equal       (rsp.is_equal),
		.status         (rsp.status)
	);

	// Busy right after an accept: no second item slips in
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while sequencer busy");

	// The stored date reported has a month of 1 to 12, a day of at least 1 and a nonzero year
	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.cur_month >= 4'd1) && (rsp.cur_month <= 4'd12) &&
		(rsp.cur_day >= 5'd1) && (rsp.cur_year != 14'd0))
		else $error("stored date out of calendar range");

	// An invalid given date yields no difference and no compare flags
	a_bad_date_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == gda_pkg::ST_BAD_DATE)) |->
		((rsp.day_difference == 23'sd0) && !rsp.is_less && !rsp.is_equal))
		else $error("invalid date result carries data");

	// Compare flags are exclusive
	a_less_eq_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.is_less && rsp.is_equal))
		else $error("less and equal both set");

endmodule
